### hdl/gcd_pkg.sv
`default_nettype none

package gcd_pkg;

    localparam int unsigned CORDIC_STAGES = 24;
    localparam int unsigned NUM_ANG       = 3;
    localparam int unsigned TAG_ROT_W     = 2 * NUM_ANG;
    localparam int unsigned ROOT_BITS     = 31;
    localparam int unsigned RADIUS_W      = 23;
    localparam int unsigned DIST_W        = 22;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378388;
    localparam logic signed [32:0]  GAIN_Q30     = 33'sd652032874;
    localparam logic signed [33:0]  PI_Q30       = 34'sd3373259426;
    localparam logic signed [33:0]  ONE_Q30      = 34'sd1073741824;
    localparam logic [28:0]         RAD_K        = 29'd341157299;
    localparam logic [DIST_W-1:0]   DIST_MAX     = 22'd2635500;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [32:0] x;
        logic [32:0] y;
        logic [32:0] z;
    } t_cordic;

    typedef struct packed {
        logic [60:0] rem;
        logic [60:0] root;
    } t_sqrt;

endpackage

`default_nettype wire

### hdl/gcd_rot_cell.sv
`default_nettype none

module gcd_rot_cell #(
    parameter int unsigned SHIFT = 0,
    parameter int unsigned TAG_W = 1
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_en,
    input  wire logic                                       i_valid,
    input  wire logic [TAG_W-1:0]                           i_tag,
    input  gcd_pkg::t_cordic [gcd_pkg::NUM_ANG-1:0]         i_data,
    output logic                                            o_valid,
    output logic [TAG_W-1:0]                                o_tag,
    output gcd_pkg::t_cordic [gcd_pkg::NUM_ANG-1:0]         o_data
);

    localparam logic signed [32:0] ATAN = $signed({1'b0, gcd_pkg::ATAN_Q30[SHIFT]});

    gcd_pkg::t_cordic [gcd_pkg::NUM_ANG-1:0] n_data;

    always_comb begin
        for (int k = 0; k < gcd_pkg::NUM_ANG; k++) begin
            if (i_data[k].z[32]) begin
                n_data[k].x = 33'($signed(i_data[k].x) + ($signed(i_data[k].y) >>> SHIFT));
                n_data[k].y = 33'($signed(i_data[k].y) - ($signed(i_data[k].x) >>> SHIFT));
                n_data[k].z = 33'($signed(i_data[k].z) + ATAN);
            end else begin
                n_data[k].x = 33'($signed(i_data[k].x) - ($signed(i_data[k].y) >>> SHIFT));
                n_data[k].y = 33'($signed(i_data[k].y) + ($signed(i_data[k].x) >>> SHIFT));
                n_data[k].z = 33'($signed(i_data[k].z) - ATAN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_tag  <= i_tag;
            o_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### hdl/gcd_sqrt_cell.sv
`default_nettype none

module gcd_sqrt_cell #(
    parameter int unsigned BITPOS = 0,
    parameter int unsigned TAG_W  = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [TAG_W-1:0] i_tag,
    input  gcd_pkg::t_sqrt        i_data,
    output logic                  o_valid,
    output logic [TAG_W-1:0]      o_tag,
    output gcd_pkg::t_sqrt        o_data
);

    localparam logic [60:0] BIT = 61'(1) << (2 * BITPOS);

    logic [61:0]    w_sum;
    gcd_pkg::t_sqrt n_data;

    assign w_sum = {1'b0, i_data.root} + {1'b0, BIT};

    always_comb begin
        if ({1'b0, i_data.rem} >= w_sum) begin
            n_data.rem  = i_data.rem - w_sum[60:0];
            n_data.root = (i_data.root >> 1) + BIT;
        end else begin
            n_data.rem  = i_data.rem;
            n_data.root = i_data.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_tag  <= i_tag;
            o_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### hdl/gcd_vec_cell.sv
`default_nettype none

module gcd_vec_cell #(
    parameter int unsigned SHIFT = 0,
    parameter int unsigned TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [TAG_W-1:0] i_tag,
    input  gcd_pkg::t_cordic      i_data,
    output logic                  o_valid,
    output logic [TAG_W-1:0]      o_tag,
    output gcd_pkg::t_cordic      o_data
);

    localparam logic signed [32:0] ATAN = $signed({1'b0, gcd_pkg::ATAN_Q30[SHIFT]});

    gcd_pkg::t_cordic n_data;

    always_comb begin
        if (!i_data.y[32]) begin
            n_data.x = 33'($signed(i_data.x) + ($signed(i_data.y) >>> SHIFT));
            n_data.y = 33'($signed(i_data.y) - ($signed(i_data.x) >>> SHIFT));
            n_data.z = 33'($signed(i_data.z) + ATAN);
        end else begin
            n_data.x = 33'($signed(i_data.x) - ($signed(i_data.y) >>> SHIFT));
            n_data.y = 33'($signed(i_data.y) + ($signed(i_data.x) >>> SHIFT));
            n_data.z = 33'($signed(i_data.z) - ATAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_tag  <= i_tag;
            o_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### hdl/great_circle_distance_top.sv
`default_nettype none

// Great-circle distance by the spherical law of cosines, in hundredths of a km.
// A fully pipelined datapath takes one coordinate pair per clock and returns one
// distance per pair, in order. It is a chain of CORDIC_STAGES rotation cells
// (sin/cos of both latitudes and the longitude difference), a chain of 31
// square-root cells, a chain of CORDIC_STAGES vectoring cells for acos, and ten
// fixed stages for angle folding, products and scaling. A result not taken
// stalls the whole pipeline. The user must write the radius register through the
// config port only while idle, not enforced by the block; it resets to 6378388 m.
module great_circle_distance_top #(
    parameter int unsigned CORDIC_STAGES = gcd_pkg::CORDIC_STAGES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [7:0]             i_dep_lat_deg,
    input  wire logic [5:0]                    i_dep_lat_min,
    input  wire logic [5:0]                    i_dep_lat_sec,
    input  wire logic signed [8:0]             i_dep_lon_deg,
    input  wire logic [5:0]                    i_dep_lon_min,
    input  wire logic [5:0]                    i_dep_lon_sec,
    input  wire logic signed [7:0]             i_arr_lat_deg,
    input  wire logic [5:0]                    i_arr_lat_min,
    input  wire logic [5:0]                    i_arr_lat_sec,
    input  wire logic signed [8:0]             i_arr_lon_deg,
    input  wire logic [5:0]                    i_arr_lon_min,
    input  wire logic [5:0]                    i_arr_lon_sec,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gcd_pkg::RADIUS_W-1:0]  i_cfg_sphere_radius_m,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [gcd_pkg::DIST_W-1:0]         o_distance_centikm
);

    localparam int unsigned N  = CORDIC_STAGES;
    localparam int unsigned NS = gcd_pkg::ROOT_BITS;
    localparam int unsigned NA = gcd_pkg::NUM_ANG;

    typedef struct packed {
        logic [18:0] m;
        logic        neg;
        logic        cneg;
    } t_fold;

    function automatic logic signed [22:0] f_arcsec(input logic signed [8:0] deg,
                                                    input logic [5:0] mins,
                                                    input logic [5:0] secs);
        return deg * 23'sd3600 + $signed({17'd0, mins}) * 23'sd60
               + $signed({17'd0, secs});
    endfunction

    function automatic t_fold f_fold(input logic signed [22:0] a);
        logic signed [22:0] r;
        logic [22:0]        mag;
        t_fold              f;
        r = a;
        if (r >= 23'sd648000) begin
            r = r - 23'sd1296000;
        end else if (r < -23'sd648000) begin
            r = r + 23'sd1296000;
        end
        f.neg  = r[22];
        mag    = f.neg ? 23'(-r) : 23'(r);
        f.cneg = mag > 23'd324000;
        if (f.cneg) begin
            mag = 23'd648000 - mag;
        end
        f.m = mag[18:0];
        return f;
    endfunction

    function automatic logic signed [32:0] f_qmul(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        p = p + 66'sd536870912;
        return 33'(p >>> 30);
    endfunction

    logic                       w_en;
    logic [gcd_pkg::RADIUS_W-1:0] r_radius;

    logic signed [22:0] w_ang [NA];
    t_fold              r_p0_fold [NA];
    logic               r_p0_valid;

    logic [31:0]        r_p1_rad [NA];
    logic [NA*2-1:0]    r_p1_tag;
    logic               r_p1_valid;

    gcd_pkg::t_cordic [NA-1:0] w_rot_data [0:N];
    logic [NA*2-1:0]           w_rot_tag  [0:N];
    logic [N:0]                w_rot_valid;

    logic signed [32:0] n_sc_s [NA];
    logic signed [32:0] n_sc_c [NA];
    logic signed [32:0] r_p2_sd, r_p2_cd, r_p2_sa, r_p2_ca, r_p2_cl;
    logic               r_p2_valid;

    logic signed [32:0] r_p3_ss, r_p3_cc, r_p3_cl;
    logic               r_p3_valid;

    logic signed [32:0] r_p4_ss, r_p4_ccc;
    logic               r_p4_valid;

    logic signed [33:0] w_p5_sum;
    logic signed [31:0] n_p5_c;
    logic signed [31:0] r_p5_c;
    logic               r_p5_valid;

    logic signed [63:0] w_p6_sq;
    logic [63:0]        w_p6_rem;
    logic [60:0]        r_p6_rem;
    logic signed [31:0] r_p6_c;
    logic               r_p6_valid;

    gcd_pkg::t_sqrt w_sq_data [0:NS];
    logic [31:0]    w_sq_tag  [0:NS];
    logic [NS:0]    w_sq_valid;

    logic signed [31:0] w_c_fin;
    logic signed [32:0] w_abs_c;

    gcd_pkg::t_cordic w_vec_data [0:N];
    logic             w_vec_tag  [0:N];
    logic [N:0]       w_vec_valid;

    logic signed [33:0] w_z;
    logic signed [33:0] n_theta;
    logic [31:0]        r_p7_theta;
    logic               r_p7_valid;

    logic [54:0]        r_p8_prod;
    logic               r_p8_valid;

    logic [55:0]        w_p9_round;
    logic [25:0]        w_p9_q;
    logic [57:0]        w_p9_mul;
    logic [22:0]        w_p9_div;
    logic [gcd_pkg::DIST_W-1:0] n_dist;

    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_sphere_radius_m;
        end
    end

    // angles in arcseconds: departure lat, arrival lat, longitude difference
    assign w_ang[0] = f_arcsec($signed({i_dep_lat_deg[7], i_dep_lat_deg}),
                               i_dep_lat_min, i_dep_lat_sec);
    assign w_ang[1] = f_arcsec($signed({i_arr_lat_deg[7], i_arr_lat_deg}),
                               i_arr_lat_min, i_arr_lat_sec);
    assign w_ang[2] = f_arcsec(i_arr_lon_deg, i_arr_lon_min, i_arr_lon_sec)
                    - f_arcsec(i_dep_lon_deg, i_dep_lon_min, i_dep_lon_sec);

    // fold and convert to radians
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
            r_p1_valid <= 1'b0;
        end else if (w_en) begin
            r_p0_valid <= i_in_valid;
            r_p1_valid <= r_p0_valid;
        end
        if (w_en) begin
            for (int k = 0; k < NA; k++) begin
                r_p0_fold[k]        <= f_fold(w_ang[k]);
                r_p1_rad[k]         <= 32'((48'(r_p0_fold[k].m) * 48'(gcd_pkg::RAD_K)
                                           + 48'd32768) >> 16);
                r_p1_tag[2*k]       <= r_p0_fold[k].neg;
                r_p1_tag[2*k+1]     <= r_p0_fold[k].cneg;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NA; k++) begin
            w_rot_data[0][k].x = gcd_pkg::GAIN_Q30;
            w_rot_data[0][k].y = '0;
            w_rot_data[0][k].z = {1'b0, r_p1_rad[k]};
        end
    end
    assign w_rot_tag[0]   = r_p1_tag;
    assign w_rot_valid[0] = r_p1_valid;

    for (genvar g = 0; g < N; g++) begin : g_rot
        gcd_rot_cell #(
            .SHIFT (g),
            .TAG_W (NA * 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rot_valid[g]),
            .i_tag   (w_rot_tag[g]),
            .i_data  (w_rot_data[g]),
            .o_valid (w_rot_valid[g+1]),
            .o_tag   (w_rot_tag[g+1]),
            .o_data  (w_rot_data[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < NA; k++) begin
            n_sc_s[k] = w_rot_tag[N][2*k]   ? -$signed(w_rot_data[N][k].y)
                                            :  $signed(w_rot_data[N][k].y);
            n_sc_c[k] = w_rot_tag[N][2*k+1] ? -$signed(w_rot_data[N][k].x)
                                            :  $signed(w_rot_data[N][k].x);
        end
    end

    // law of cosines argument, clamped
    assign w_p5_sum = r_p4_ss + r_p4_ccc;

    always_comb begin
        if (w_p5_sum > gcd_pkg::ONE_Q30) begin
            n_p5_c = 32'(gcd_pkg::ONE_Q30);
        end else if (w_p5_sum < -gcd_pkg::ONE_Q30) begin
            n_p5_c = 32'(-gcd_pkg::ONE_Q30);
        end else begin
            n_p5_c = 32'(w_p5_sum);
        end
    end

    assign w_p6_sq  = r_p5_c * r_p5_c;
    assign w_p6_rem = 64'h1000_0000_0000_0000 - 64'(w_p6_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_p5_valid <= 1'b0;
            r_p6_valid <= 1'b0;
        end else if (w_en) begin
            r_p2_valid <= w_rot_valid[N];
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_p5_valid <= r_p4_valid;
            r_p6_valid <= r_p5_valid;
        end
        if (w_en) begin
            r_p2_sd  <= n_sc_s[0];
            r_p2_cd  <= n_sc_c[0];
            r_p2_sa  <= n_sc_s[1];
            r_p2_ca  <= n_sc_c[1];
            r_p2_cl  <= n_sc_c[2];
            r_p3_ss  <= f_qmul(r_p2_sa, r_p2_sd);
            r_p3_cc  <= f_qmul(r_p2_ca, r_p2_cd);
            r_p3_cl  <= r_p2_cl;
            r_p4_ss  <= r_p3_ss;
            r_p4_ccc <= f_qmul(r_p3_cc, r_p3_cl);
            r_p5_c   <= n_p5_c;
            r_p6_c   <= r_p5_c;
            r_p6_rem <= w_p6_rem[60:0];
        end
    end

    // sqrt(1 - c*c), one result bit per cell
    assign w_sq_data[0].rem  = r_p6_rem;
    assign w_sq_data[0].root = '0;
    assign w_sq_tag[0]       = r_p6_c;
    assign w_sq_valid[0]     = r_p6_valid;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        gcd_sqrt_cell #(
            .BITPOS (NS - 1 - g),
            .TAG_W  (32)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[g]),
            .i_tag   (w_sq_tag[g]),
            .i_data  (w_sq_data[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_tag   (w_sq_tag[g+1]),
            .o_data  (w_sq_data[g+1])
        );
    end

    assign w_c_fin = $signed(w_sq_tag[NS]);
    assign w_abs_c = w_c_fin[31] ? -33'(w_c_fin) : 33'(w_c_fin);

    assign w_vec_data[0].x = w_abs_c;
    assign w_vec_data[0].y = {2'b00, w_sq_data[NS].root[30:0]};
    assign w_vec_data[0].z = '0;
    assign w_vec_tag[0]    = w_c_fin[31];
    assign w_vec_valid[0]  = w_sq_valid[NS];

    for (genvar g = 0; g < N; g++) begin : g_vec
        gcd_vec_cell #(
            .SHIFT (g),
            .TAG_W (1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vec_valid[g]),
            .i_tag   (w_vec_tag[g]),
            .i_data  (w_vec_data[g]),
            .o_valid (w_vec_valid[g+1]),
            .o_tag   (w_vec_tag[g+1]),
            .o_data  (w_vec_data[g+1])
        );
    end

    // acos fixup and clamp
    assign w_z = 34'($signed(w_vec_data[N].z));

    always_comb begin
        n_theta = w_z[33] ? '0 : w_z;
        if (w_vec_tag[N]) begin
            n_theta = gcd_pkg::PI_Q30 - n_theta;
        end
        if (n_theta[33]) begin
            n_theta = '0;
        end else if (n_theta > gcd_pkg::PI_Q30) begin
            n_theta = gcd_pkg::PI_Q30;
        end
    end

    // scale: round(radius * theta / (10 * 2^30)), divide by ten via reciprocal
    assign w_p9_round = 56'(r_p8_prod) + 56'(64'd5 << 30);
    assign w_p9_q     = w_p9_round[55:30];
    assign w_p9_mul   = 58'(w_p9_q) * 58'(32'hCCCC_CCCD);
    assign w_p9_div   = w_p9_mul[57:35];
    assign n_dist     = (w_p9_div > 23'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                             : w_p9_div[21:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p7_valid  <= 1'b0;
            r_p8_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p7_valid  <= w_vec_valid[N];
            r_p8_valid  <= r_p7_valid;
            o_out_valid <= r_p8_valid;
        end
        if (w_en) begin
            r_p7_theta         <= n_theta[31:0];
            r_p8_prod          <= 55'(r_radius) * 55'(r_p7_theta);
            o_distance_centikm <= n_dist;
        end
    end

endmodule

`default_nettype wire

### hdl/gcd_checker.sv
`default_nettype none

module gcd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [gcd_pkg::DIST_W-1:0]   o_distance_centikm
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat visible right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while the pipeline is stalled");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance_centikm <= gcd_pkg::DIST_MAX))
        else $error("distance above saturation limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_distance_centikm)))
        else $error("stalled result beat changed");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (.*);

`default_nettype wire
